>>> design/wsfd_pkg.sv
// shared types and constants for the websocket frame deframer
// no dependencies
package wsfd_pkg;

  // width of the max payload length register
  localparam int MAXLEN_W = 22;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(2 * 1024 * 1024);

  // default width of the payload position counter
  localparam int LENGTH_BITS_DEF = 22;

  // register map (byte address of each register)
  localparam logic [2:0] ADDR_MAX_LEN = 3'd0;

  // opcodes
  localparam logic [3:0] OP_DATA_MAX = 4'h2;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;

  // second header byte length codes
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_CLOSE     = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

  // one result beat
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic [1:0] kind;
    logic       last;
    logic [1:0] err;
  } res_t;

endpackage

>>> design/websocket_frame_deframer_unit.sv
// websocket frame deframer, one received byte per beat
// path: a result is written into the queue when its byte is accepted, then moves into the output register
// throughput: one byte per cycle while the queue has room; the parser state is updated on each accepted byte and the
//   two-entry queue plus output register decouple input and output stalls
// reset: synchronous active-low rst_n clears parser, queue and output valid, and
//   sets max_payload_length to 2097152; a close frame or oversize length halts
//   the parser until the next reset
module websocket_frame_deframer_unit import wsfd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [4:0]  out_tuser,  // [0] has_byte, [2:1] out_kind, [4:3] error_code
  output logic        out_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [MAXLEN_W-1:0] max_len_r;
  logic                acc;
  logic                push;
  res_t                push_res;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  res_t                q_head;
  res_t                out_res;

  // register port: always ready, write lands on the access cycle
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_LEN) ? 32'(max_len_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAXLEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_LEN) begin
      max_len_r <= pwdata[MAXLEN_W-1:0];
    end
  end

  // a byte is taken whenever the queue has room, halted or not
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // parser: every accepted beat updates state unless halted, at most one result pushed
  wsfd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_byte  (in_tdata),
    .max_len  (max_len_r),
    .push     (push),
    .push_res (push_res)
  );

  // short queue so the parser keeps going while the output stage is stalled
  wsfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // output register
  wsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = {out_res.err, out_res.kind, out_res.has_byte};
  assign out_tlast = out_res.last;

endmodule

>>> design/wsfd_front.sv
// front end: header parser, unmasking and result classification
// depends on wsfd_pkg
module wsfd_front import wsfd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          in_byte,
  input  logic [MAXLEN_W-1:0] max_len,
  output logic                push,
  output res_t                push_res
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  // bits of the length that can stay below the position limit
  localparam int LOWB = (LENGTH_BITS < MAXLEN_W) ? LENGTH_BITS : MAXLEN_W;
  localparam int CMPW = (LENGTH_BITS + 1 > MAXLEN_W) ? LENGTH_BITS + 1 : MAXLEN_W;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_r, mask_nxt;
  logic [MAXLEN_W-1:0]    len_r, len_nxt;
  logic                   hi_r, hi_nxt;
  logic                   long_r, long_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic                   halted_r, halted_nxt;

  logic                   len_known;
  logic                   hdr_done;
  logic                   over;
  logic                   last;
  logic [7:0]             kb;
  logic [7:0]             val;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    hi_nxt     = hi_r;
    long_nxt   = long_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    push       = 1'b0;
    push_res   = '0;
    len_known  = 1'b0;
    hdr_done   = 1'b0;
    over       = 1'b0;
    last       = 1'b0;
    kb         = 8'd0;
    val        = in_byte;

    if (acc && !halted_r) begin
      case (phase_r)
        PH_FIRST: begin
          opcode_nxt = in_byte[3:0];
          phase_nxt  = PH_SECOND;
        end
        PH_SECOND: begin
          mask_nxt = in_byte[7];
          key_nxt  = 32'd0;
          cnt_nxt  = 3'd0;
          hi_nxt   = 1'b0;
          if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
            long_nxt  = (in_byte[6:0] == LEN_CODE_64);
            len_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_nxt   = MAXLEN_W'(in_byte[6:0]);
            len_known = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // anything shifted past the kept width is too large for sure
          hi_nxt  = hi_r | (|len_r[MAXLEN_W-1:MAXLEN_W-8]);
          len_nxt = {len_r[MAXLEN_W-9:0], in_byte};
          cnt_nxt = cnt_r + 3'd1;
          if ((cnt_nxt == 3'd0 && long_r) || (cnt_nxt == 3'd2 && !long_r)) begin
            len_known = 1'b1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_nxt >= 3'd4) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          case (pos_r[1:0])
            2'd0:    kb = key_r[31:24];
            2'd1:    kb = key_r[23:16];
            2'd2:    kb = key_r[15:8];
            default: kb = key_r[7:0];
          endcase
          val     = mask_r ? (in_byte ^ kb) : in_byte;
          last    = (CMPW'(pos_r) + CMPW'(1)) >= CMPW'(len_r);
          pos_nxt = pos_r + LENGTH_BITS'(1);
          if (last) begin
            phase_nxt = PH_FIRST;
          end
          if (opcode_r <= OP_DATA_MAX) begin
            push     = 1'b1;
            push_res = '{data: val, has_byte: 1'b1, kind: KIND_DATA, last: last,
                         err: ERR_NONE};
          end else if (opcode_r == OP_PING) begin
            push     = 1'b1;
            push_res = '{data: val, has_byte: 1'b1, kind: KIND_PING, last: last,
                         err: ERR_NONE};
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase

      // length check as soon as the length is complete
      if (len_known) begin
        over = hi_nxt || (len_nxt > max_len) || ((len_nxt >> LOWB) != '0);
        if (over) begin
          halted_nxt = 1'b1;
          push       = 1'b1;
          push_res   = '{data: 8'd0, has_byte: 1'b0, kind: KIND_ERROR, last: 1'b1,
                         err: ERR_TOO_LARGE};
        end else begin
          cnt_nxt = 3'd0;
          if (mask_nxt) begin
            phase_nxt = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end

      if (hdr_done) begin
        if (opcode_nxt == OP_CLOSE) begin
          halted_nxt = 1'b1;
          push       = 1'b1;
          push_res   = '{data: 8'd0, has_byte: 1'b0, kind: KIND_ERROR, last: 1'b1,
                         err: ERR_CLOSE};
        end else begin
          pos_nxt = '0;
          if (len_nxt == '0) begin
            phase_nxt = PH_FIRST;
            // empty ping still reports its end
            if (opcode_nxt == OP_PING) begin
              push     = 1'b1;
              push_res = '{data: 8'd0, has_byte: 1'b0, kind: KIND_PING, last: 1'b1,
                           err: ERR_NONE};
            end
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      opcode_r <= 4'd0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      hi_r     <= 1'b0;
      long_r   <= 1'b0;
      cnt_r    <= 3'd0;
      key_r    <= 32'd0;
      pos_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      hi_r     <= hi_nxt;
      long_r   <= long_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> design/wsfd_queue.sv
// two-entry result queue between the parser and the output stage
// depends on wsfd_pkg
module wsfd_queue import wsfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  input  logic pop,
  output logic full,
  output logic empty,
  output res_t head
);

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/wsfd_back.sv
// output stage: holds one result beat until the sink takes it
// depends on wsfd_pkg
module wsfd_back import wsfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  res_t q_head,
  output logic q_pop,
  input  logic out_tready,
  output logic out_tvalid,
  output res_t out_res
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign q_pop      = !q_empty && (!valid_r || out_tready);
  assign valid_nxt  = q_pop || (valid_r && !out_tready);
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
